// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros: assertion macros for the RTL files
// Each macro takes a label, the clock, the active-low reset, an antecedent and
// a consequent.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/gzhp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gzhp_pkg: types and constants of the gzip header parser
// Phase and status codes, word structs and the parser state record.
// ----------------------------------------------------------------------------
package gzhp_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int FIELD_BITS  = 16;
  localparam int LEN_BITS    = 32;

  localparam logic [7:0]  MAGIC0      = 8'h1f;
  localparam logic [7:0]  MAGIC1      = 8'h8b;
  localparam logic [7:0]  METHOD_DEFL = 8'h08;
  localparam logic [7:0]  FLG_RSVD    = 8'hE0;
  localparam logic [7:0]  FLG_EXTRA   = 8'h04;
  localparam logic [7:0]  FLG_NAME    = 8'h08;
  localparam logic [7:0]  FLG_COMMENT = 8'h10;
  localparam logic [7:0]  FLG_HCRC    = 8'h02;
  localparam logic [FIELD_BITS-1:0] FIXED_BYTES = FIELD_BITS'(6);

  typedef enum logic [3:0] {
    PH_MAGIC0 = 4'd0,
    PH_MAGIC1 = 4'd1,
    PH_METHOD = 4'd2,
    PH_FLAGS  = 4'd3,
    PH_FIXED  = 4'd4,
    PH_XLEN0  = 4'd5,
    PH_XLEN1  = 4'd6,
    PH_XDATA  = 4'd7,
    PH_NAME   = 4'd8,
    PH_COMM   = 4'd9,
    PH_HCRC0  = 4'd10,
    PH_HCRC1  = 4'd11,
    PH_DONE   = 4'd12
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MAGIC  = 2'd1,
    ST_METHOD = 2'd2,
    ST_TRUNC  = 2'd3
  } status_t;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic       new_stream;
  } in_word_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [LEN_BITS-1:0] header_length;
    logic [4:0]          flag_bits;
  } out_word_t;

  typedef struct packed {
    phase_t                 phase;
    logic [FIELD_BITS-1:0]  field_count;
    logic [OFFSET_BITS-1:0] byte_offset;
    logic [7:0]             saved_flags;
    logic                   finished;
  } parse_state_t;

  // First optional section at or after the given phase that the flags ask for.
  function automatic phase_t next_section(input phase_t from, input logic [7:0] flags);
    phase_t ph;
    ph = PH_DONE;
    if (from <= PH_HCRC0 && (flags & FLG_HCRC) != 8'h00) ph = PH_HCRC0;
    if (from <= PH_COMM && (flags & FLG_COMMENT) != 8'h00) ph = PH_COMM;
    if (from <= PH_NAME && (flags & FLG_NAME) != 8'h00) ph = PH_NAME;
    if (from <= PH_XLEN0 && (flags & FLG_EXTRA) != 8'h00) ph = PH_XLEN0;
    return ph;
  endfunction

endpackage

// ----- rtl/gzip_header_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gzip_header_parser_core: gzip member header checker
// Takes a gzip stream one byte per word, checks the member header and gives
// one verdict word with status, header length and flag bits per stream.
// ----------------------------------------------------------------------------
//   channel | ports                        | word
//   input   | in_valid, in_ready, in_data  | func, data_byte, new_stream
//   output  | out_valid, out_ready, out_data | status, header_length, flag_bits
//
// One word is taken per cycle unless a stalled output holds it; a verdict passes through both registers.
// The input register feeds a single step of parsing logic, whose verdict lands
// in the output register. Reset clears the parser state and both valid flags.
// A stalled output holds the pipe; the input register still empties into the
// parser whenever the output register is free or being read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gzip_header_parser_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gzhp_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gzhp_pkg::out_word_t out_data
);
  import gzhp_pkg::*;

  logic         s1_valid_r;
  in_word_t     s1_word_r;
  parse_state_t state_r;
  parse_state_t state_nxt;
  logic         out_valid_r;
  out_word_t    out_word_r;
  logic         res_valid;
  out_word_t    res_word;
  logic         adv;

  gzhp_step u_step (
    .cur       (state_r),
    .item      (s1_word_r),
    .nxt       (state_nxt),
    .res_valid (res_valid),
    .res       (res_word)
  );

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      state_r.phase       <= PH_MAGIC0;
      state_r.field_count <= '0;
      state_r.byte_offset <= '0;
      state_r.saved_flags <= '0;
      state_r.finished    <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        state_r     <= state_nxt;
        out_valid_r <= res_valid;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_word_r <= in_data;
    end
    if (adv && res_valid) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  `ASSERT_NEXT(a_silent_after_verdict, clk, rst_n,
               adv && state_r.finished && !s1_word_r.new_stream, !out_valid_r)
  `ASSERT_NEXT(a_verdict_sets_finished, clk, rst_n, adv && res_valid, state_r.finished)
  `ASSERT_NEXT(a_ok_means_done, clk, rst_n,
               adv && res_valid && res_word.status == ST_OK, state_r.phase == PH_DONE)
  `ASSERT_NEXT(a_offset_grows, clk, rst_n, adv && !s1_word_r.new_stream,
               state_r.byte_offset >= $past(state_r.byte_offset))
  `ASSERT_SAME(a_stall_needs_word, clk, rst_n, !in_ready, s1_valid_r && out_valid_r)

endmodule

// ----- rtl/gzhp_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gzhp_step: one parsing step
// Takes the parser state and one input word, gives the next state and the
// verdict word when this word settles the header.
// ----------------------------------------------------------------------------
module gzhp_step (
  input  gzhp_pkg::parse_state_t cur,
  input  gzhp_pkg::in_word_t     item,
  output gzhp_pkg::parse_state_t nxt,
  output logic                   res_valid,
  output gzhp_pkg::out_word_t    res
);
  import gzhp_pkg::*;

  logic    vd_valid;
  status_t vd_status;
  logic [63:0] off_ext;

  // Next state and verdict code.
  always_comb begin
    logic [7:0] b;
    logic       chk_done;
    b         = item.data_byte;
    chk_done  = 1'b0;
    nxt       = cur;
    vd_valid  = 1'b0;
    vd_status = ST_OK;
    if (item.new_stream) begin
      nxt.phase       = PH_MAGIC0;
      nxt.field_count = '0;
      nxt.byte_offset = '0;
      nxt.saved_flags = '0;
      nxt.finished    = 1'b0;
    end
    if (!nxt.finished) begin
      if (item.func) begin
        vd_valid  = 1'b1;
        vd_status = ST_TRUNC;
      end else begin
        if (nxt.byte_offset != {OFFSET_BITS{1'b1}}) begin
          nxt.byte_offset = nxt.byte_offset + OFFSET_BITS'(1);
        end
        case (nxt.phase)
          PH_MAGIC0: begin
            if (b != MAGIC0) begin
              vd_valid  = 1'b1;
              vd_status = ST_MAGIC;
            end else begin
              nxt.phase = PH_MAGIC1;
            end
          end
          PH_MAGIC1: begin
            if (b != MAGIC1) begin
              vd_valid  = 1'b1;
              vd_status = ST_MAGIC;
            end else begin
              nxt.phase = PH_METHOD;
            end
          end
          PH_METHOD: begin
            // A bad method is only marked here; the verdict waits for the flag byte.
            nxt.field_count = (b != METHOD_DEFL) ? FIELD_BITS'(1) : '0;
            nxt.phase       = PH_FLAGS;
          end
          PH_FLAGS: begin
            nxt.saved_flags = b;
            if (nxt.field_count != '0 || (b & FLG_RSVD) != 8'h00) begin
              vd_valid  = 1'b1;
              vd_status = ST_METHOD;
            end else begin
              nxt.field_count = '0;
              nxt.phase       = PH_FIXED;
            end
          end
          PH_FIXED: begin
            nxt.field_count = nxt.field_count + FIELD_BITS'(1);
            if (nxt.field_count >= FIXED_BYTES) begin
              nxt.field_count = '0;
              nxt.phase       = next_section(PH_XLEN0, nxt.saved_flags);
              chk_done        = 1'b1;
            end
          end
          PH_XLEN0: begin
            nxt.field_count = FIELD_BITS'(b);
            nxt.phase       = PH_XLEN1;
          end
          PH_XLEN1: begin
            nxt.field_count = {b, nxt.field_count[7:0]};
            nxt.phase       = (nxt.field_count != '0) ? PH_XDATA
                                                      : next_section(PH_NAME, nxt.saved_flags);
            chk_done        = 1'b1;
          end
          PH_XDATA: begin
            nxt.field_count = nxt.field_count - FIELD_BITS'(1);
            if (nxt.field_count == '0) begin
              nxt.phase = next_section(PH_NAME, nxt.saved_flags);
              chk_done  = 1'b1;
            end
          end
          PH_NAME: begin
            if (b == 8'h00) begin
              nxt.phase = next_section(PH_COMM, nxt.saved_flags);
              chk_done  = 1'b1;
            end
          end
          PH_COMM: begin
            if (b == 8'h00) begin
              nxt.phase = next_section(PH_HCRC0, nxt.saved_flags);
              chk_done  = 1'b1;
            end
          end
          PH_HCRC0: begin
            nxt.phase = PH_HCRC1;
          end
          PH_HCRC1: begin
            nxt.phase = PH_DONE;
            chk_done  = 1'b1;
          end
          default: begin
            nxt.phase = PH_DONE;
            chk_done  = 1'b1;
          end
        endcase
        if (chk_done && nxt.phase == PH_DONE) begin
          vd_valid  = 1'b1;
          vd_status = ST_OK;
        end
      end
      if (vd_valid) begin
        nxt.finished = 1'b1;
      end
    end
  end

  assign off_ext = 64'(nxt.byte_offset);

  // Verdict word.
  always_comb begin
    res_valid         = vd_valid;
    res.status        = vd_status;
    res.header_length = (off_ext > 64'h0000_0000_FFFF_FFFF) ? {LEN_BITS{1'b1}}
                                                          : off_ext[LEN_BITS-1:0];
    res.flag_bits     = nxt.saved_flags[4:0];
  end

endmodule

// ----- verif/gzip_header_parser_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gzip_header_parser_core_tb: self-checking bench for the gzip header parser
// Feeds byte words made of whole gzip headers with random content, damaged
// and cut-short headers and loose noise. A header tracker in the bench
// predicts each verdict word, and the monitor compares the words that come
// out with those predictions while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module gzip_header_parser_core_tb;
  import gzhp_pkg::*;

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PHASE_ITEMS    = 185;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  in_word_t  byte_q[$];
  out_word_t verdict_q[$];
  int        words_queued;
  int        mismatches    = 0;
  int        tx_idle_pct   = 0;
  int        rx_stall_pct  = 0;
  logic      hold_kick     = 1'b0;
  int        hold_left;
  int        quiet_cycles;

  // Header tracker state.
  phase_t      hp_phase;
  logic [15:0] hp_count;
  logic [OFFSET_BITS-1:0] hp_offset;
  logic [7:0]  hp_flags;
  logic        hp_done;

  gzip_header_parser_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic clear_tracker();
    hp_phase  = PH_MAGIC0;
    hp_count  = '0;
    hp_offset = '0;
    hp_flags  = '0;
    hp_done   = 1'b0;
  endtask

  // The first optional field that the flag byte asks for, from the given step on.
  function automatic phase_t section_after(input phase_t from);
    if (from <= PH_XLEN0 && (hp_flags & FLG_EXTRA) != 8'h00) return PH_XLEN0;
    if (from <= PH_NAME && (hp_flags & FLG_NAME) != 8'h00) return PH_NAME;
    if (from <= PH_COMM && (hp_flags & FLG_COMMENT) != 8'h00) return PH_COMM;
    if (from <= PH_HCRC0 && (hp_flags & FLG_HCRC) != 8'h00) return PH_HCRC0;
    return PH_DONE;
  endfunction

  task automatic track_header(input in_word_t w);
    logic [7:0] b;
    logic       give;
    status_t    st;
    out_word_t  v;
    b    = w.data_byte;
    give = 1'b0;
    st   = ST_OK;
    if (w.new_stream) clear_tracker();
    if (hp_done) return;
    if (w.func) begin
      give = 1'b1;
      st   = ST_TRUNC;
    end else begin
      if (~&hp_offset) hp_offset = hp_offset + 1'b1;
      case (hp_phase)
        PH_MAGIC0: begin
          if (b != MAGIC0) begin
            give = 1'b1;
            st   = ST_MAGIC;
          end else hp_phase = PH_MAGIC1;
        end
        PH_MAGIC1: begin
          if (b != MAGIC1) begin
            give = 1'b1;
            st   = ST_MAGIC;
          end else hp_phase = PH_METHOD;
        end
        PH_METHOD: begin
          // A bad method is only remembered; the verdict waits for the flag byte.
          hp_count = (b != METHOD_DEFL) ? 16'd1 : 16'd0;
          hp_phase = PH_FLAGS;
        end
        PH_FLAGS: begin
          hp_flags = b;
          if (hp_count != 0 || (b & FLG_RSVD) != 8'h00) begin
            give = 1'b1;
            st   = ST_METHOD;
          end else begin
            hp_count = '0;
            hp_phase = PH_FIXED;
          end
        end
        PH_FIXED: begin
          hp_count = hp_count + 1'b1;
          if (hp_count == FIXED_BYTES) begin
            hp_count = '0;
            hp_phase = section_after(PH_XLEN0);
          end
        end
        PH_XLEN0: begin
          hp_count = {8'h00, b};
          hp_phase = PH_XLEN1;
        end
        PH_XLEN1: begin
          hp_count = {b, hp_count[7:0]};
          hp_phase = (hp_count != 0) ? PH_XDATA : section_after(PH_NAME);
        end
        PH_XDATA: begin
          hp_count = hp_count - 1'b1;
          if (hp_count == 0) hp_phase = section_after(PH_NAME);
        end
        PH_NAME: begin
          if (b == 8'h00) hp_phase = section_after(PH_COMM);
        end
        PH_COMM: begin
          if (b == 8'h00) hp_phase = section_after(PH_HCRC0);
        end
        PH_HCRC0: hp_phase = PH_HCRC1;
        PH_HCRC1: hp_phase = PH_DONE;
        default:  hp_phase = PH_DONE;
      endcase
      if (!give && hp_phase == PH_DONE) give = 1'b1;
    end
    if (give) begin
      hp_done         = 1'b1;
      v.status        = st;
      v.header_length = (64'(hp_offset) > 64'h0000_0000_FFFF_FFFF) ? {LEN_BITS{1'b1}}
                                                                   : LEN_BITS'(hp_offset);
      v.flag_bits     = hp_flags[4:0];
      verdict_q.push_back(v);
    end
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch: %s got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  task automatic push_word(input logic f, input logic [7:0] b, input logic ns,
                           input bit counted);
    in_word_t w;
    w.func       = f;
    w.data_byte  = b;
    w.new_stream = ns;
    byte_q.push_back(w);
    if (counted) words_queued++;
  endtask

  // One gzip stream: a well-formed header with random content, which is then
  // sent whole, cut short, abandoned for a restart, or damaged.
  task automatic add_stream();
    logic [7:0] hdr[$];
    logic [7:0] flg;
    int         n;
    int         cut;
    int         k;
    int         pick;
    flg = 8'($urandom_range(31));
    hdr.push_back(MAGIC0);
    hdr.push_back(MAGIC1);
    hdr.push_back(METHOD_DEFL);
    hdr.push_back(flg);
    repeat (6) hdr.push_back(8'($urandom_range(255)));
    if ((flg & FLG_EXTRA) != 8'h00) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(4);
      hdr.push_back(n[7:0]);
      hdr.push_back(n[15:8]);
      repeat (n) hdr.push_back(8'($urandom_range(255)));
    end
    if ((flg & FLG_NAME) != 8'h00) begin
      repeat ($urandom_range(5)) hdr.push_back(8'($urandom_range(255, 1)));
      hdr.push_back(8'h00);
    end
    if ((flg & FLG_COMMENT) != 8'h00) begin
      repeat ($urandom_range(5)) hdr.push_back(8'($urandom_range(255, 1)));
      hdr.push_back(8'h00);
    end
    if ((flg & FLG_HCRC) != 8'h00) repeat (2) hdr.push_back(8'($urandom_range(255)));

    pick = $urandom_range(99);
    cut  = hdr.size();
    if (pick < 60) begin
      cut = hdr.size();
    end else if (pick < 72) begin
      cut = $urandom_range(hdr.size() - 1);
    end else if (pick < 80) begin
      cut = $urandom_range(hdr.size() - 1, 1);
    end else if (pick < 92) begin
      k = $urandom_range(3);
      if (k == 3) hdr[3] = hdr[3] | (8'h20 << $urandom_range(2));
      else hdr[k] = hdr[k] ^ 8'($urandom_range(255, 1));
    end else begin
      k = $urandom_range(hdr.size() - 1);
      hdr[k] = 8'($urandom_range(255));
    end

    for (int i = 0; i < cut; i++) push_word(1'b0, hdr[i], i == 0, 1'b1);
    if (pick >= 60 && pick < 72) begin
      push_word(1'b1, 8'($urandom_range(255)), cut == 0, 1'b1);
    end else if (pick < 60) begin
      // Words after the verdict are ignored by the block.
      repeat ($urandom_range(2)) push_word(1'($urandom_range(1)), 8'($urandom_range(255)),
                                           1'b0, 1'b0);
    end
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || in_valid || verdict_q.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input bit squeeze);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    words_queued = 0;
    while (words_queued < PHASE_ITEMS) begin
      if ($urandom_range(19) == 0) begin
        push_word(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      end else begin
        add_stream();
      end
    end
    if (squeeze) begin
      // Hold the receiver off while the sender keeps offering, so the block fills.
      hold_kick = 1'b1;
      @(negedge clk);
      hold_kick = 1'b0;
    end
    wait_drained();
  endtask

  // Driver: offers the next queued word and keeps it steady until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      clear_tracker();
    end else begin
      if (in_valid && in_ready) track_header(in_data);
      if (!in_valid || in_ready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= byte_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) hold_left <= 0;
    else if (hold_kick) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Monitor: checks each verdict word against the oldest prediction.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        note_mismatch("verdict with none predicted", out_data.header_length, 32'h0);
      end else begin
        want = verdict_q.pop_front();
        if (out_data.status !== want.status)
          note_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.header_length !== want.header_length)
          note_mismatch("header_length", out_data.header_length, want.header_length);
        if (out_data.flag_bits !== want.flag_bits)
          note_mismatch("flag_bits", 32'(out_data.flag_bits), 32'(want.flag_bits));
      end
    end
    out_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (byte_q.size() == 0 && !in_valid && verdict_q.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words. The first header starts straight after reset without a
    // restart and carries an empty extra field.
    push_word(1'b0, MAGIC0, 1'b0, 1'b1);
    push_word(1'b0, MAGIC1, 1'b0, 1'b1);
    push_word(1'b0, METHOD_DEFL, 1'b0, 1'b1);
    push_word(1'b0, FLG_EXTRA, 1'b0, 1'b1);
    repeat (3) begin
      push_word(1'b0, 8'h00, 1'b0, 1'b1);
      push_word(1'b0, 8'hff, 1'b0, 1'b1);
    end
    push_word(1'b0, 8'h00, 1'b0, 1'b1);
    push_word(1'b0, 8'h00, 1'b0, 1'b1);
    // End of input as the very first word of a stream.
    push_word(1'b1, 8'h00, 1'b1, 1'b1);
    // Bad first magic byte, then an end of input that must be ignored.
    push_word(1'b0, 8'h00, 1'b1, 1'b1);
    push_word(1'b1, 8'hff, 1'b0, 1'b1);
    // Bad second magic byte.
    push_word(1'b0, MAGIC0, 1'b1, 1'b1);
    push_word(1'b0, 8'h00, 1'b0, 1'b1);
    // Bad method: the verdict comes with the flag byte.
    push_word(1'b0, MAGIC0, 1'b1, 1'b1);
    push_word(1'b0, MAGIC1, 1'b0, 1'b1);
    push_word(1'b0, 8'hff, 1'b0, 1'b1);
    push_word(1'b0, 8'hff, 1'b0, 1'b1);
    // Reserved flag bit set.
    push_word(1'b0, MAGIC0, 1'b1, 1'b1);
    push_word(1'b0, MAGIC1, 1'b0, 1'b1);
    push_word(1'b0, METHOD_DEFL, 1'b0, 1'b1);
    push_word(1'b0, 8'h20, 1'b0, 1'b1);
    wait_drained();

    run_phase(0, 0, 1'b1);
    run_phase(79, 0, 1'b0);
    run_phase(0, 79, 1'b0);
    run_phase(32, 32, 1'b0);

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
